[rtl/core/lfuc_pkg.sv]
// Shared types and constants of the LFU cache store: entry size, entry word layout,
// operation codes, controller states and the scan summary record.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package lfuc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int WORD_W  = 32;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic [WORD_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] data;
    logic [WORD_W-1:0] count;
    logic [WORD_W-1:0] stamp;
  } lfuc_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } lfuc_state_t;

  // Summary gathered by one sweep over the entries.
  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  slot;
    logic [WORD_W-1:0] data;
    logic [WORD_W-1:0] count;
    logic              havefree;
    logic [IDX_W-1:0]  freeslot;
    logic              have;
    logic [IDX_W-1:0]  best;
  } lfuc_scan_t;

endpackage

`default_nettype wire

[rtl/core/lfuc_scan.sv]
// Sweep accumulator of the LFU cache store: takes one entry a cycle from the entry
// memory and tracks the key match, the first free slot and the eviction victim.
// Depends on lfuc_pkg.
`default_nettype none

module lfuc_scan (
  input  wire logic                       clk,
  input  wire logic                       start,
  input  wire logic                       in_valid,
  input  wire logic [lfuc_pkg::IDX_W-1:0] in_idx,
  input  wire logic                       in_used,
  input  wire lfuc_pkg::lfuc_entry_t      in_entry,
  input  wire logic [lfuc_pkg::WORD_W-1:0] lookup_key,
  input  wire logic [lfuc_pkg::WORD_W-1:0] use_clock,
  output lfuc_pkg::lfuc_scan_t            summary
);

  lfuc_pkg::lfuc_scan_t summary_next;
  logic [lfuc_pkg::WORD_W-1:0] bcnt;
  logic [lfuc_pkg::WORD_W-1:0] bcnt_next;
  logic [lfuc_pkg::WORD_W-1:0] bage;
  logic [lfuc_pkg::WORD_W-1:0] bage_next;
  logic [lfuc_pkg::WORD_W-1:0] age;
  logic                        better;

  // Age is taken modulo 2^32, so a very old stamp may look young.
  assign age    = use_clock - in_entry.stamp;
  assign better = !summary.have || (in_entry.count < bcnt) ||
                  ((in_entry.count == bcnt) && (age > bage));

  always_comb begin
    summary_next = summary;
    bcnt_next    = bcnt;
    bage_next    = bage;
    if (start) begin
      summary_next.found    = 1'b0;
      summary_next.havefree = 1'b0;
      summary_next.have     = 1'b0;
    end else if (in_valid) begin
      if (in_used) begin
        if (!summary.found && (in_entry.key == lookup_key)) begin
          summary_next.found = 1'b1;
          summary_next.slot  = in_idx;
          summary_next.data  = in_entry.data;
          summary_next.count = in_entry.count;
        end
        // Strict comparisons keep the lowest slot among equal candidates.
        if (better) begin
          summary_next.have = 1'b1;
          summary_next.best = in_idx;
          bcnt_next         = in_entry.count;
          bage_next         = age;
        end
      end else if (!summary.havefree) begin
        summary_next.havefree = 1'b1;
        summary_next.freeslot = in_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    summary <= summary_next;
    bcnt    <= bcnt_next;
    bage    <= bage_next;
  end

endmodule

`default_nettype wire

[rtl/core/lfu_cache_store.sv]
// Top level of the LFU cache store: handshakes, controller, entry memory, valid bits
// and result register.
// Depends on lfuc_pkg and lfuc_scan.
//
// Usage. Requests arrive on the s_ channel: s_tuser carries the opcode (get or put)
// and s_tdata the key and the value. Each accepted beat yields exactly one result
// beat on the m_ channel with the hit flag, the value read by a get hit and the
// eviction flag. The capacity register is written through cfg_we/cfg_wdata; the user
// must write it only while no request is in flight, which the block does not enforce.
// Values above the entry count act as the entry count. One request is handled at a
// time: the controller sweeps every entry of the single-port entry memory, one read
// a cycle, then writes back at most once and registers the result; the next request
// is accepted only after that write-back.
// Reset clears the valid bits, the occupancy, the use clock and the controller, and
// sets the capacity to 16; no clearing pass is needed. If the receiver stalls, the
// result waits in the output register while the next request is accepted and swept;
// that request's write-back then waits until the register is free.
`default_nettype none

module lfu_cache_store (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [lfuc_pkg::CAP_W-1:0] cfg_wdata,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [63:0]              s_tdata,  // lookup_key[31:0], write_value[63:32]
  input  wire logic [0:0]               s_tuser,  // opcode[0]
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic [39:0]                   m_tdata   // hit[0], read_value[32:1], evicted[33]
);

  lfuc_pkg::lfuc_state_t state;
  lfuc_pkg::lfuc_state_t state_next;

  logic [lfuc_pkg::CAP_W-1:0]  capacity;
  logic [lfuc_pkg::CNT_W-1:0]  occupancy;
  logic [lfuc_pkg::WORD_W-1:0] use_clock;
  logic [lfuc_pkg::ENTRIES-1:0] entry_valid;

  logic                        op;
  logic [lfuc_pkg::WORD_W-1:0] key;
  logic [lfuc_pkg::WORD_W-1:0] val;

  lfuc_pkg::lfuc_entry_t mem [lfuc_pkg::ENTRIES];
  lfuc_pkg::lfuc_entry_t mem_q;
  lfuc_pkg::lfuc_entry_t wr_word;
  logic [lfuc_pkg::IDX_W-1:0] wr_addr;

  logic [lfuc_pkg::CNT_W-1:0] rd_addr;
  logic                       rd_pend;
  logic [lfuc_pkg::IDX_W-1:0] rd_idx;

  logic accept;
  logic rd_issue;
  logic scan_start;
  logic scan_last;
  logic commit;
  logic out_free;

  lfuc_pkg::lfuc_scan_t summary;

  logic [lfuc_pkg::CNT_W-1:0]  cap_eff;
  logic                        do_touch;
  logic                        do_insert;
  logic                        need_evict;
  logic                        mem_we;
  logic [lfuc_pkg::WORD_W-1:0] count_inc;

  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign scan_last = rd_pend && (rd_idx == lfuc_pkg::IDX_W'(lfuc_pkg::ENTRIES - 1));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      lfuc_pkg::ST_IDLE:  if (accept) state_next = lfuc_pkg::ST_SCAN;
      lfuc_pkg::ST_SCAN:  if (scan_last) state_next = lfuc_pkg::ST_WRITE;
      lfuc_pkg::ST_WRITE: if (out_free) state_next = lfuc_pkg::ST_IDLE;
      default:            state_next = lfuc_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    s_tready   = 1'b0;
    rd_issue   = 1'b0;
    scan_start = 1'b0;
    commit     = 1'b0;
    case (state)
      lfuc_pkg::ST_IDLE: begin
        s_tready   = !rst;
        scan_start = 1'b1;
      end
      lfuc_pkg::ST_SCAN: begin
        rd_issue = (rd_addr < lfuc_pkg::CNT_W'(lfuc_pkg::ENTRIES));
      end
      lfuc_pkg::ST_WRITE: begin
        commit = out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfuc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lfuc_pkg::CAP_W'(16);
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= s_tuser[0];
      key <= s_tdata[31:0];
      val <= s_tdata[63:32];
    end
  end

  // Sweep address and the tag that marks a valid read word in mem_q.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_issue;
      if (accept) begin
        rd_addr <= '0;
      end else if (rd_issue) begin
        rd_addr <= rd_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= rd_addr[lfuc_pkg::IDX_W-1:0];
  end

  lfuc_scan u_scan (
    .clk        (clk),
    .start      (scan_start),
    .in_valid   (rd_pend),
    .in_idx     (rd_idx),
    .in_used    (entry_valid[rd_idx]),
    .in_entry   (mem_q),
    .lookup_key (key),
    .use_clock  (use_clock),
    .summary    (summary)
  );

  // Write-back decision.
  always_comb begin
    if (32'(capacity) > lfuc_pkg::ENTRIES) begin
      cap_eff = lfuc_pkg::CNT_W'(lfuc_pkg::ENTRIES);
    end else begin
      cap_eff = lfuc_pkg::CNT_W'(capacity);
    end
  end

  assign do_touch   = summary.found && ((op == lfuc_pkg::OP_GET) || (cap_eff != '0));
  assign do_insert  = !summary.found && (op == lfuc_pkg::OP_PUT) && (cap_eff != '0);
  assign need_evict = (occupancy >= cap_eff) || !summary.havefree;
  assign count_inc  = (summary.count == lfuc_pkg::COUNT_MAX) ? summary.count
                                                             : summary.count + 1'b1;
  assign mem_we     = commit && (do_touch || do_insert);

  always_comb begin
    wr_word.key   = key;
    wr_word.stamp = use_clock;
    if (do_touch) begin
      wr_addr       = summary.slot;
      wr_word.data  = (op == lfuc_pkg::OP_PUT) ? val : summary.data;
      wr_word.count = count_inc;
    end else begin
      wr_addr       = need_evict ? summary.best : summary.freeslot;
      wr_word.data  = val;
      wr_word.count = lfuc_pkg::WORD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_word;
    end
    if (rd_issue) begin
      mem_q <= mem[rd_addr[lfuc_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      occupancy   <= '0;
      use_clock   <= '0;
    end else if (mem_we) begin
      use_clock <= use_clock + 1'b1;
      if (do_insert) begin
        entry_valid[wr_addr] <= 1'b1;
        if (!need_evict) begin
          occupancy <= occupancy + 1'b1;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata[0]     <= summary.found;
      m_tdata[32:1]  <= (summary.found && (op == lfuc_pkg::OP_GET)) ? summary.data : '0;
      m_tdata[33]    <= do_insert && need_evict && summary.have;
      m_tdata[39:34] <= '0;
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (rst)
    32'(occupancy) == $countones(entry_valid))
    else $error("occupancy differs from the number of valid entries");

  assert property (@(posedge clk) disable iff (rst)
    32'(occupancy) <= lfuc_pkg::ENTRIES)
    else $error("occupancy exceeds the entry count");

  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (use_clock != $past(use_clock))) |->
      (use_clock == $past(use_clock) + 32'd1))
    else $error("use clock moved by other than one");

  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(m_tvalid)) |-> ($past(state) == lfuc_pkg::ST_WRITE))
    else $error("result beat raised outside write-back");

  assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == lfuc_pkg::ST_SCAN) && (rd_addr == '0) && !rd_pend)
    else $error("sweep did not start cleanly after a request beat");
`endif

endmodule

`default_nettype wire

[test/lfu_cache_store_tb.sv]
// Self-checking testbench for lfu_cache_store: drives get and put requests over the
// stream ports, predicts each result with a behavioural cache model and checks every beat.
// Depends on lfuc_pkg and the lfu_cache_store RTL.
`timescale 1ns / 100ps

module lfu_cache_store_tb;

  localparam int KEY_POOL_SIZE = 24;
  localparam int PHASE_ITEMS   = 140;
  localparam int HOLD_AFTER    = 300;
  localparam int LONG_HOLD     = 300;

  typedef struct packed {
    logic                        op;
    logic [lfuc_pkg::WORD_W-1:0] key;
    logic [lfuc_pkg::WORD_W-1:0] val;
  } cache_req_t;

  typedef struct packed {
    logic                        hit;
    logic [lfuc_pkg::WORD_W-1:0] rdata;
    logic                        evicted;
  } cache_resp_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [lfuc_pkg::CAP_W-1:0] cfg_wdata = '0;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [63:0]                s_tdata = '0;   // lookup_key[31:0], write_value[63:32]
  logic [0:0]                 s_tuser = '0;   // opcode[0]
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [39:0]                m_tdata;        // hit[0], read_value[32:1], evicted[33]

  // Predicted cache contents and configuration.
  logic                        slot_live [lfuc_pkg::ENTRIES];
  logic [lfuc_pkg::WORD_W-1:0] slot_key  [lfuc_pkg::ENTRIES];
  logic [lfuc_pkg::WORD_W-1:0] slot_val  [lfuc_pkg::ENTRIES];
  logic [lfuc_pkg::WORD_W-1:0] slot_uses [lfuc_pkg::ENTRIES];
  logic [lfuc_pkg::WORD_W-1:0] slot_seen [lfuc_pkg::ENTRIES];
  int unsigned                 fill_level = 0;
  logic [lfuc_pkg::WORD_W-1:0] use_tick = '0;
  logic [lfuc_pkg::CAP_W-1:0]  cap_mirror = 5'd16;

  cache_req_t                  pending_reqs[$];
  cache_resp_t                 expected_resps[$];
  cache_req_t                  offered;
  logic [lfuc_pkg::WORD_W-1:0] key_pool [KEY_POOL_SIZE];
  int unsigned                 items_issued = 0;
  int unsigned                 results_checked = 0;
  int unsigned                 error_count = 0;
  logic                        steady_run = 1'b0;
  int unsigned                 hold_left = 0;
  logic                        hold_done = 1'b0;

  lfu_cache_store u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("lfu_cache_store verification failed");
    $finish;
  end

  function automatic void touch_slot(int idx);
    if (slot_uses[idx] != '1) slot_uses[idx] = slot_uses[idx] + 1;
    slot_seen[idx] = use_tick;
    use_tick = use_tick + 1;
  endfunction

  function automatic cache_resp_t lookup_and_update(cache_req_t rq);
    cache_resp_t                 rs;
    int unsigned                 eff_cap;
    int                          match_idx;
    int                          free_idx;
    int                          dst;
    logic                        have_victim;
    logic [lfuc_pkg::WORD_W-1:0] best_uses;
    logic [lfuc_pkg::WORD_W-1:0] best_age;
    logic [lfuc_pkg::WORD_W-1:0] age;
    rs = '0;
    eff_cap = (cap_mirror > lfuc_pkg::ENTRIES) ? lfuc_pkg::ENTRIES : cap_mirror;
    match_idx = -1;
    free_idx = -1;
    for (int i = 0; i < lfuc_pkg::ENTRIES; i++) begin
      if (slot_live[i]) begin
        if (match_idx < 0 && slot_key[i] == rq.key) match_idx = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    rs.hit = (match_idx >= 0);
    if (rq.op == lfuc_pkg::OP_GET) begin
      if (match_idx >= 0) begin
        rs.rdata = slot_val[match_idx];
        touch_slot(match_idx);
      end
    end else if (eff_cap != 0) begin
      if (match_idx >= 0) begin
        slot_val[match_idx] = rq.val;
        touch_slot(match_idx);
      end else begin
        if (fill_level >= eff_cap || free_idx < 0) begin
          // Victim: lowest use count, then greatest age, then lowest slot.
          have_victim = 1'b0;
          dst = 0;
          best_uses = '0;
          best_age = '0;
          for (int i = 0; i < lfuc_pkg::ENTRIES; i++) begin
            if (slot_live[i]) begin
              age = use_tick - slot_seen[i];
              if (!have_victim || slot_uses[i] < best_uses ||
                  (slot_uses[i] == best_uses && age > best_age)) begin
                have_victim = 1'b1;
                dst = i;
                best_uses = slot_uses[i];
                best_age = age;
              end
            end
          end
          rs.evicted = have_victim;
        end else begin
          dst = free_idx;
          fill_level++;
        end
        slot_live[dst] = 1'b1;
        slot_key[dst]  = rq.key;
        slot_val[dst]  = rq.val;
        slot_uses[dst] = 1;
        slot_seen[dst] = use_tick;
        use_tick = use_tick + 1;
      end
    end
    return rs;
  endfunction

  // Sender: offers queued requests and predicts each one as it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_resps.push_back(lookup_and_update(offered));
      end
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() != 0 && (steady_run || $urandom_range(99) >= 12)) begin
          offered = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {offered.val, offered.key};
          s_tuser  <= offered.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every result beat and applies back-pressure, once for a long stretch.
  always @(posedge clk) begin
    cache_resp_t want;
    cache_resp_t got;
    if (rst) begin
      m_tready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.hit = m_tdata[0];
        got.rdata = m_tdata[32:1];
        got.evicted = m_tdata[33];
        results_checked++;
        if (expected_resps.size() == 0) begin
          $display("%0t: result beat with none expected, got hit=%0b value=%h evicted=%0b",
                   $time, got.hit, got.rdata, got.evicted);
          error_count++;
        end else begin
          want = expected_resps.pop_front();
          if (got.hit !== want.hit) begin
            $display("%0t: hit expected %0b got %0b", $time, want.hit, got.hit);
            error_count++;
          end
          if (got.rdata !== want.rdata) begin
            $display("%0t: read_value expected %h got %h", $time, want.rdata, got.rdata);
            error_count++;
          end
          if (got.evicted !== want.evicted) begin
            $display("%0t: evicted expected %0b got %0b", $time, want.evicted, got.evicted);
            error_count++;
          end
        end
      end
      if (!hold_done && results_checked >= HOLD_AFTER) begin
        hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        m_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady_run || ($urandom_range(99) >= 12);
      end
    end
  end

  task automatic queue_req(logic op, logic [lfuc_pkg::WORD_W-1:0] key,
                           logic [lfuc_pkg::WORD_W-1:0] val);
    cache_req_t rq;
    rq.op = op;
    rq.key = key;
    rq.val = val;
    pending_reqs.push_back(rq);
    items_issued++;
  endtask

  task automatic wait_drained();
    while (results_checked != items_issued) @(posedge clk);
  endtask

  // Only called while nothing is in flight.
  task automatic write_capacity(logic [lfuc_pkg::CAP_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cap_mirror = value;
    cfg_we <= 1'b0;
  endtask

  function automatic cache_req_t random_req();
    cache_req_t  rq;
    int unsigned roll;
    roll = $urandom_range(99);
    rq.op = ($urandom_range(99) < 45) ? lfuc_pkg::OP_PUT : lfuc_pkg::OP_GET;
    rq.key = (roll < 85) ? key_pool[$urandom_range(KEY_POOL_SIZE - 1)] : $urandom();
    rq.val = $urandom();
    return rq;
  endfunction

  initial begin
    logic [lfuc_pkg::CAP_W-1:0] phase_caps [10];
    cache_req_t                 rq;
    phase_caps = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd12, 5'd31, 5'd3, 5'd16, 5'd8, 5'd20};
    for (int i = 0; i < lfuc_pkg::ENTRIES; i++) slot_live[i] = 1'b0;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty cache, extreme keys and values, hits, update in place.
    queue_req(lfuc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
    queue_req(lfuc_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_req(lfuc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_req(lfuc_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_req(lfuc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_req(lfuc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
    queue_req(lfuc_pkg::OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_req(lfuc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
    queue_req(lfuc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_req(lfuc_pkg::OP_PUT, 32'h0000_0000, 32'h1234_5678);
    queue_req(lfuc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
    queue_req(lfuc_pkg::OP_GET, 32'h5A5A_5A5A, 32'h0000_0000);
    wait_drained();

    // Capacity lowered below the number of entries held: new keys evict.
    write_capacity(5'd2);
    queue_req(lfuc_pkg::OP_PUT, 32'hA5A5_A5A5, 32'h0F0F_0F0F);
    queue_req(lfuc_pkg::OP_PUT, 32'h0000_0001, 32'hF0F0_F0F0);
    queue_req(lfuc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
    wait_drained();

    // Zero capacity: puts change nothing, gets still see held entries.
    write_capacity(5'd0);
    queue_req(lfuc_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0001);
    queue_req(lfuc_pkg::OP_PUT, 32'h1357_2468, 32'h0000_0002);
    queue_req(lfuc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
    queue_req(lfuc_pkg::OP_GET, 32'h1357_2468, 32'h0000_0000);
    wait_drained();

    // A capacity above the entry count acts as the entry count.
    write_capacity(5'd31);
    queue_req(lfuc_pkg::OP_PUT, 32'h1357_2468, 32'hFEDC_BA98);
    queue_req(lfuc_pkg::OP_GET, 32'h1357_2468, 32'h0000_0000);
    queue_req(lfuc_pkg::OP_PUT, 32'h7FFF_FFFE, 32'h0000_0003);
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      write_capacity(phase_caps[p]);
      steady_run = (p == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        rq = random_req();
        queue_req(rq.op, rq.key, rq.val);
      end
      wait_drained();
    end
    steady_run = 1'b0;

    repeat (lfuc_pkg::ENTRIES + 8) @(posedge clk);
    if (expected_resps.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_resps.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("lfu_cache_store verification clean");
    end else begin
      $display("lfu_cache_store verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/lfuc_pkg.sv
rtl/core/lfuc_scan.sv
rtl/core/lfu_cache_store.sv
test/lfu_cache_store_tb.sv
